[hdl/chs_pkg.sv]
// chs_pkg: shared types, constants and the arctangent table for the
// compass heading and steering block. No dependencies.

package chs_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NUM_ITER      = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int STEP_W        = $clog2(ATAN_LEN + 1);

    localparam int VEC_W         = 26;
    localparam int ANG_W         = 25;
    localparam int QANG_W        = 11;

    localparam int DEG90_Z       = 5898240;
    localparam int HALF_TURN_16  = 2880;
    localparam int FULL_TURN_16  = 5760;
    localparam int BIAS_DEG      = 180;
    localparam int WRAP_DEG      = 360;
    localparam int RIGHT_LIMIT   = 170;
    localparam int LEFT_LIMIT    = 190;
    localparam int DIR_RESET     = 60;

    localparam logic [1:0] DRIVE_RIGHT = 2'b01;
    localparam logic [1:0] DRIVE_LEFT  = 2'b10;

    typedef struct packed {
        logic [7:0] x_high;
        logic [7:0] x_low;
        logic [7:0] y_high;
        logic [7:0] y_low;
    } chs_in_t;

    typedef struct packed {
        logic [12:0] heading;
        logic [8:0]  relative_angle;
        logic        drive_first;
        logic        drive_second;
    } chs_out_t;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest
    function automatic logic [21:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/compass_heading_steer.sv]
// compass_heading_steer: magnetometer heading (atan2) and steering decision.
// Depends on chs_pkg and chs_cordic.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  chs_pkg::chs_in_t  (X, Y bytes)
//  out       output     out_valid/out_stall  chs_pkg::chs_out_t (heading, angle, drive)
//  cfg       input      cfg_wr_en            cfg_wr_data (initial_direction)
//
// From acceptance, a transaction makes 16 passes through the shared CORDIC
// shift/add stage, then the rounding and offset steps, before its result is valid.
// A new transaction is accepted once the previous one is in the output register.
// Reset: drive bits cleared, initial_direction 60, output empty.
// A stalled output holds its result; the last step waits until the register frees.

module compass_heading_steer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  chs_pkg::chs_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output chs_pkg::chs_out_t   out_data,
    input  logic                cfg_wr_en,
    input  logic [8:0]          cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_HEAD,
        ST_REL,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [8:0]                     dir_reg;
    logic                           xneg_reg;
    logic                           yneg_reg;
    logic                           zero_reg;
    logic [12:0]                    heading_reg;
    logic [8:0]                     rel_reg;
    logic [1:0]                     drive_reg;
    logic                           out_valid_reg;
    chs_pkg::chs_out_t              out_reg;

    logic signed [15:0]             xv;
    logic signed [15:0]             yv;
    logic signed [16:0]             xe;
    logic signed [16:0]             ye;
    logic [15:0]                    ax;
    logic [15:0]                    ay;
    logic                           start;
    logic                           cordic_done;
    logic [chs_pkg::QANG_W-1:0]     qangle;

    logic [12:0]                    head_raw;
    logic [12:0]                    head_next;
    logic signed [15:0]             s_val;
    logic [15:0]                    s_mag;
    logic [11:0]                    q_mag;
    logic signed [12:0]             r_trunc;
    logic signed [12:0]             r_wrap;
    logic [1:0]                     drive_next;

    always_comb
    begin
        xv    = $signed({in_data.x_high, in_data.x_low});
        yv    = $signed({in_data.y_high, in_data.y_low});
        xe    = {xv[15], xv};
        ye    = {yv[15], yv};
        ax    = xe[16] ? 16'(-xe) : 16'(xe);
        ay    = ye[16] ? 16'(-ye) : 16'(ye);
        start = (state_reg == ST_IDLE) && in_valid;
    end

    chs_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .ax    (ax),
        .ay    (ay),
        .done  (cordic_done),
        .angle (qangle)
    );

    // quadrant placement
    always_comb
    begin
        unique case ({xneg_reg, yneg_reg})
            2'b00:   head_raw = 13'(qangle);
            2'b10:   head_raw = 13'(chs_pkg::HALF_TURN_16) - 13'(qangle);
            2'b11:   head_raw = 13'(chs_pkg::HALF_TURN_16) + 13'(qangle);
            default: head_raw = 13'(chs_pkg::FULL_TURN_16) - 13'(qangle);
        endcase
        if (zero_reg)
            head_next = '0;
        else if (head_raw >= 13'(chs_pkg::FULL_TURN_16))
            head_next = head_raw - 13'(chs_pkg::FULL_TURN_16);
        else
            head_next = head_raw;
    end

    // offset, truncate toward zero, single wrap
    always_comb
    begin
        s_val   = 16'sd2880 - $signed({3'b000, dir_reg, 4'b0000})
                + $signed({3'b000, heading_reg});
        s_mag   = s_val[15] ? 16'(-s_val) : 16'(s_val);
        q_mag   = s_mag[15:4];
        r_trunc = s_val[15] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
        if (r_trunc < 0)
            r_wrap = r_trunc + 13'sd360;
        else if (r_trunc > 13'sd360)
            r_wrap = r_trunc - 13'sd360;
        else
            r_wrap = r_trunc;
    end

    always_comb
    begin
        priority if (rel_reg > 9'd0 && rel_reg < 9'(chs_pkg::RIGHT_LIMIT))
            drive_next = chs_pkg::DRIVE_RIGHT;
        else if (rel_reg > 9'(chs_pkg::LEFT_LIMIT) && rel_reg < 9'(chs_pkg::WRAP_DEG))
            drive_next = chs_pkg::DRIVE_LEFT;
        else
            drive_next = drive_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= 9'(chs_pkg::DIR_RESET);
        else if (cfg_wr_en)
            dir_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            xneg_reg      <= 1'b0;
            yneg_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            heading_reg   <= '0;
            rel_reg       <= '0;
            drive_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        xneg_reg  <= xv[15];
                        yneg_reg  <= yv[15];
                        zero_reg  <= (xv == 16'sd0) && (yv == 16'sd0);
                        state_reg <= ST_CORDIC;
                    end
                end
                ST_CORDIC:
                begin
                    if (cordic_done)
                        state_reg <= ST_HEAD;
                end
                ST_HEAD:
                begin
                    heading_reg <= head_next;
                    state_reg   <= ST_REL;
                end
                ST_REL:
                begin
                    rel_reg   <= r_wrap[8:0];
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        drive_reg              <= drive_next;
                        out_reg.heading        <= heading_reg;
                        out_reg.relative_angle <= rel_reg;
                        out_reg.drive_first    <= drive_next[1];
                        out_reg.drive_second   <= drive_next[0];
                        state_reg              <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[hdl/chs_cordic.sv]
// chs_cordic: iterative first-quadrant CORDIC in vectoring mode, one
// shift/add/accumulate pass per cycle, angle out in 1/16 degree.
// Depends on chs_pkg.

module chs_cordic (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [15:0]                ax,
    input  logic [15:0]                ay,
    output logic                       done,
    output logic [chs_pkg::QANG_W-1:0] angle
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_ROUND
    } state_t;

    state_t                              state_reg;
    logic [chs_pkg::STEP_W-1:0]          step_reg;
    logic signed [chs_pkg::VEC_W-1:0]    x_reg;
    logic signed [chs_pkg::VEC_W-1:0]    y_reg;
    logic signed [chs_pkg::ANG_W-1:0]    z_reg;
    logic                                done_reg;
    logic [chs_pkg::QANG_W-1:0]          angle_reg;

    logic signed [chs_pkg::VEC_W-1:0]    dx;
    logic signed [chs_pkg::VEC_W-1:0]    dy;
    logic signed [chs_pkg::ANG_W-1:0]    dz;
    logic signed [chs_pkg::VEC_W-1:0]    x_next;
    logic signed [chs_pkg::VEC_W-1:0]    y_next;
    logic signed [chs_pkg::ANG_W-1:0]    z_next;
    logic [22:0]                         z_clamp;
    logic [23:0]                         z_rnd;

    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        dz = $signed({3'b000, chs_pkg::atan_entry(step_reg)});
        if (!y_reg[chs_pkg::VEC_W-1])
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + dz;
        end
        else
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - dz;
        end
    end

    always_comb
    begin
        priority if (z_reg[chs_pkg::ANG_W-1])
            z_clamp = '0;
        else if (z_reg > chs_pkg::ANG_W'(chs_pkg::DEG90_Z))
            z_clamp = 23'(chs_pkg::DEG90_Z);
        else
            z_clamp = z_reg[22:0];
        z_rnd = {1'b0, z_clamp} + 24'd2048;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            done_reg  <= 1'b0;
            angle_reg <= '0;
        end
        else
        begin
            done_reg <= (state_reg == ST_ROUND);
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= $signed({2'b00, ax, 8'h00});
                        y_reg     <= $signed({2'b00, ay, 8'h00});
                        z_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_ITER;
                    end
                end
                ST_ITER:
                begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == chs_pkg::STEP_W'(chs_pkg::NUM_ITER - 1))
                        state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    angle_reg <= z_rnd[12 +: chs_pkg::QANG_W];
                    state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

[tb/compass_heading_steer_tb.sv]
// Self-checking testbench for compass_heading_steer: random and directed
// magnetometer samples, heading and steering checked against an in-bench CORDIC model.
// Depends on chs_pkg and the compass_heading_steer RTL.

module compass_heading_steer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD   = 400;
    localparam int SETTLE_CYC  = 40;
    localparam int RAND_PER_PH = 50;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    chs_pkg::chs_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    chs_pkg::chs_out_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [8:0] cfg_wr_data = '0;

    // atan(2^-i) in 2^-16 degree
    longint atan_q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    logic [15:0] corner_vals [0:4] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};

    chs_pkg::chs_in_t    sample_q [$];
    chs_pkg::chs_out_t   steer_exp_q [$];
    logic [8:0] dir_model = 9'(chs_pkg::DIR_RESET);
    logic [1:0] drive_state = 2'b00;
    logic       bursts_on = 1'b1;
    int         send_gap = 0;
    int         hold_left = 0;
    bit         long_hold_done = 1'b0;
    int         samples_in = 0;
    int         results_seen = 0;
    int         fail_count = 0;
    int         dir_settings = 1;

    compass_heading_steer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic chs_pkg::chs_out_t predict_steer(chs_pkg::chs_in_t s);
        longint xv, yv, cx, cy, z, dx, dy, ang, head, sum, rel;
        chs_pkg::chs_out_t res;
        xv = $signed({s.x_high, s.x_low});
        yv = $signed({s.y_high, s.y_low});
        head = 0;
        if (xv != 0 || yv != 0)
        begin
            cx = (xv < 0 ? -xv : xv) * 256;
            cy = (yv < 0 ? -yv : yv) * 256;
            z = 0;
            for (int i = 0; i < chs_pkg::NUM_ITER; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx += dx;
                    cy -= dy;
                    z += atan_q16[i];
                end
                else
                begin
                    cx -= dx;
                    cy += dy;
                    z -= atan_q16[i];
                end
            end
            if (z < 0)
                z = 0;
            if (z > chs_pkg::DEG90_Z)
                z = chs_pkg::DEG90_Z;
            ang = (z + 2048) >>> 12;
            if (xv >= 0 && yv >= 0)
                head = ang;
            else if (xv < 0 && yv >= 0)
                head = chs_pkg::HALF_TURN_16 - ang;
            else if (xv < 0)
                head = chs_pkg::HALF_TURN_16 + ang;
            else
                head = chs_pkg::FULL_TURN_16 - ang;
            if (head >= chs_pkg::FULL_TURN_16)
                head -= chs_pkg::FULL_TURN_16;
        end
        sum = (chs_pkg::BIAS_DEG - longint'(dir_model)) * 16 + head;
        rel = sum / 16;
        if (rel < 0)
            rel += chs_pkg::WRAP_DEG;
        else if (rel > chs_pkg::WRAP_DEG)
            rel -= chs_pkg::WRAP_DEG;
        if (rel > 0 && rel < chs_pkg::RIGHT_LIMIT)
            drive_state = chs_pkg::DRIVE_RIGHT;
        else if (rel > chs_pkg::LEFT_LIMIT && rel < chs_pkg::WRAP_DEG)
            drive_state = chs_pkg::DRIVE_LEFT;
        res.heading        = head[12:0];
        res.relative_angle = rel[8:0];
        res.drive_first    = drive_state[1];
        res.drive_second   = drive_state[0];
        return res;
    endfunction

    function automatic chs_pkg::chs_in_t rand_sample();
        logic [15:0] xv, yv;
        int kind;
        kind = $urandom_range(0, 9);
        xv = 16'($urandom);
        yv = 16'($urandom);
        case (kind)
            5, 6:
            begin
                xv = 16'($urandom_range(0, 8)) - 16'd4;
                yv = 16'($urandom_range(0, 8)) - 16'd4;
            end
            7: yv = 16'($urandom_range(0, 6)) - 16'd3;
            8: xv = 16'($urandom_range(0, 6)) - 16'd3;
            9:
            begin
                xv = corner_vals[$urandom_range(0, 4)];
                yv = corner_vals[$urandom_range(0, 4)];
            end
            default: ;
        endcase
        return {xv, yv};
    endfunction

    function automatic void field_ok(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                steer_exp_q.push_back(predict_steer(in_data));
                samples_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    in_data <= sample_q.pop_front();
                    in_valid <= 1'b1;
                    if (bursts_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 17);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (steer_exp_q.size() == 0)
                begin
                    $error("unexpected transaction: heading %0d, relative_angle %0d",
                           out_data.heading, out_data.relative_angle);
                    fail_count++;
                end
                else
                begin
                    chs_pkg::chs_out_t exp_r;
                    exp_r = steer_exp_q.pop_front();
                    field_ok("heading", exp_r.heading, out_data.heading);
                    field_ok("relative_angle", exp_r.relative_angle, out_data.relative_angle);
                    field_ok("drive_first", exp_r.drive_first, out_data.drive_first);
                    field_ok("drive_second", exp_r.drive_second, out_data.drive_second);
                end
                results_seen++;
            end
            if (hold_left == 0)
            begin
                if (!long_hold_done && results_seen >= 100)
                begin
                    hold_left = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
                else if (bursts_on && $urandom_range(0, 9) == 0)
                begin
                    hold_left = $urandom_range(1, 17);
                end
            end
            out_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    task automatic push_xy(logic [15:0] xv, logic [15:0] yv);
        sample_q.push_back({xv, yv});
    endtask

    task automatic push_random(int n);
        repeat (n)
            sample_q.push_back(rand_sample());
    endtask

    // axis and zero samples: hit the steering bounds for chosen directions
    task automatic push_axes();
        push_xy(16'h0000, 16'h0000);
        push_xy(16'hC000, 16'h0000);
        push_xy(16'h7FFF, 16'h0000);
        push_xy(16'h0000, 16'h4000);
        push_xy(16'h0000, 16'hC000);
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || in_valid || steer_exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_dir(logic [8:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        dir_model <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        dir_settings++;
    endtask

    initial
    begin
        logic [8:0] dir_list [0:7];
        dir_list = '{9'd10, 9'd350, 9'd180, 9'd0, 9'd511, 9'd359, 9'd256, 9'd100};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_xy(16'h0000, 16'h0000);
        push_xy(16'h7FFF, 16'h0000);
        push_xy(16'h8000, 16'h0000);
        push_xy(16'h0000, 16'h7FFF);
        push_xy(16'h0000, 16'h8000);
        push_xy(16'h7FFF, 16'h7FFF);
        push_xy(16'h8000, 16'h8000);
        push_xy(16'h8000, 16'h7FFF);
        push_xy(16'h7FFF, 16'h8000);
        push_xy(16'hFFFF, 16'hFFFF);
        push_xy(16'h0001, 16'h0000);
        push_xy(16'h0000, 16'h0001);
        push_xy(16'hFFFF, 16'h0000);
        push_xy(16'h0000, 16'hFFFF);
        push_xy(16'h0001, 16'h0001);
        push_xy(16'hFFFF, 16'h0001);
        push_xy(16'h0001, 16'hFFFF);
        push_xy(16'h7FFF, 16'hFFFF);
        push_xy(16'h8000, 16'hFFFF);
        push_xy(16'h00FF, 16'hFF00);
        push_xy(16'h5A5A, 16'hA5A5);
        push_random(RAND_PER_PH);
        drain();

        foreach (dir_list[k])
        begin
            write_dir(k == 7 ? 9'($urandom_range(0, 511)) : dir_list[k]);
            push_axes();
            push_random(RAND_PER_PH);
            drain();
        end

        bursts_on <= 1'b0;
        write_dir(9'($urandom_range(0, 359)));
        push_axes();
        push_random(RAND_PER_PH);
        drain();

        $display("Summary: %0d samples sent, %0d results checked, %0d direction settings",
                 samples_in, results_seen, dir_settings);
        $display("Summary: one %0d-cycle output hold, random idling on both channels",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
